@@ design/nivr_pkg.sv @@
// Shared types and codes for the range successor table.
// No dependencies; used by nivr_cell, nivr_chain and the top level.
`timescale 1ns / 1ps

package nivr_pkg;

	// Width of a stored value and of the range bounds.
	localparam int VALUE_W = 32;

	// Operation codes carried in the input word's tuser.
	localparam int OP_W = 2;
	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_APPEND = 2'd0;
	localparam op_t OP_QUERY  = 2'd1;
	localparam op_t OP_CLEAR  = 2'd2;

	// Search token control bits handed from one cell to the next.
	typedef struct packed {
		logic active;
		logic found;
	} link_t;

endpackage

@@ design/nivr_cell.sv @@
// One table entry of the range successor table with its range comparator.
// Depends on nivr_pkg for VALUE_W and the link_t token type.
`timescale 1ns / 1ps

module nivr_cell #(
	parameter int IDX   = 0,
	parameter int IDX_W = 10,
	parameter int CNT_W = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              append_en,
	input  logic signed [nivr_pkg::VALUE_W-1:0] append_value,
	input  logic [CNT_W-1:0]                  count,
	input  logic [CNT_W-1:0]                  start,
	input  logic signed [nivr_pkg::VALUE_W-1:0] range_low,
	input  logic signed [nivr_pkg::VALUE_W-1:0] range_high,
	input  nivr_pkg::link_t                   link_in,
	input  logic [IDX_W-1:0]                  pos_in,
	output nivr_pkg::link_t                   link_out,
	output logic [IDX_W-1:0]                  pos_out
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);
	localparam logic [IDX_W-1:0] MY_POS = IDX_W'(IDX);

	logic signed [nivr_pkg::VALUE_W-1:0] value_q;
	nivr_pkg::link_t                     link_q;
	logic [IDX_W-1:0]                    pos_q;
	logic                                in_window;
	logic                                in_range;
	logic                                hit;

	// The entry is written when the table fill point reaches this cell.
	always_ff @(posedge clk) begin
		if (append_en && (count == MY_IDX)) begin
			value_q <= append_value;
		end
	end

	// Only filled entries at or after the start position may answer.
	assign in_window = (MY_IDX >= start) && (MY_IDX < count);
	assign in_range  = (value_q >= range_low) && (value_q <= range_high);
	assign hit       = link_in.active && !link_in.found && in_window && in_range;

	// Pass the token on; the first hit along the chain stamps its position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.active <= link_in.active;
			link_q.found  <= link_in.active && (link_in.found || hit);
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= hit ? MY_POS : pos_in;
	end

	assign link_out = link_q;
	assign pos_out  = pos_q;

endmodule

@@ design/nivr_chain.sv @@
// Row of nivr_cell instances, one per table entry, linked in position order.
// Depends on nivr_pkg and nivr_cell.
`timescale 1ns / 1ps

module nivr_chain #(
	parameter int TABLE_DEPTH = 1024,
	parameter int IDX_W       = 10,
	parameter int CNT_W       = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              append_en,
	input  logic signed [nivr_pkg::VALUE_W-1:0] append_value,
	input  logic [CNT_W-1:0]                  count,
	input  logic [CNT_W-1:0]                  start,
	input  logic signed [nivr_pkg::VALUE_W-1:0] range_low,
	input  logic signed [nivr_pkg::VALUE_W-1:0] range_high,
	input  logic                              launch,
	output nivr_pkg::link_t                   link_last,
	output logic [IDX_W-1:0]                  pos_last
);

	nivr_pkg::link_t  link_w [0:TABLE_DEPTH];
	logic [IDX_W-1:0] pos_w  [0:TABLE_DEPTH];

	// A fresh search token enters the first cell with nothing found yet.
	assign link_w[0].active = launch;
	assign link_w[0].found  = 1'b0;
	assign pos_w[0]         = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		nivr_cell #(
			.IDX   (i),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.append_en    (append_en),
			.append_value (append_value),
			.count        (count),
			.start        (start),
			.range_low    (range_low),
			.range_high   (range_high),
			.link_in      (link_w[i]),
			.pos_in       (pos_w[i]),
			.link_out     (link_w[i+1]),
			.pos_out      (pos_w[i+1])
		);
	end

	assign link_last = link_w[TABLE_DEPTH];
	assign pos_last  = pos_w[TABLE_DEPTH];

endmodule

@@ design/next_index_in_value_range_core.sv @@
// Range successor table: top level with the command FSM, count and output register.
// Depends on nivr_pkg and nivr_chain.
//
// Usage: every input word on the s_ channel carries one command in s_tuser:
// append a value, query, or clear the table. Appends and clears give no output
// word. A query answers with one output word on the m_ channel: m_tuser is
// the found flag, m_tdata the smallest position at or after the start whose
// value lies in [range_low, range_high], zero if none. A query sends a token
// down a row of TABLE_DEPTH cells, one cell per cycle, each cell holding one
// entry; s_tready stays low until the answer moves to the output register.
// Appends and clears are accepted on every cycle in between queries.
// The output word sits in its own register, so new commands are accepted
// while a finished answer waits for m_tready; a second answer that finishes
// while the first is still stalled is parked until the register frees up.
// Reset empties the table (count zero), drops any output word and leaves
// s_tready high.
`timescale 1ns / 1ps

module next_index_in_value_range_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// s_tdata from bit 0: item_value[31:0], start_position[CNT_W-1:0],
	// range_low[31:0], range_high[31:0], zero fill to whole bytes.
	input  logic [((3 * nivr_pkg::VALUE_W + $clog2(TABLE_DEPTH + 1) + 7) / 8) * 8 - 1:0] s_tdata,
	// s_tuser: operation[1:0].
	input  logic [nivr_pkg::OP_W-1:0]  s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// m_tdata from bit 0: position[IDX_W-1:0], zero fill to whole bytes.
	output logic [(($clog2(TABLE_DEPTH) + 7) / 8) * 8 - 1:0] m_tdata,
	// m_tuser: found.
	output logic                       m_tuser
);

	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int VW          = nivr_pkg::VALUE_W;
	localparam int OUT_TDATA_W = ((IDX_W + 7) / 8) * 8;
	localparam int START_LSB   = VW;
	localparam int LOW_LSB     = VW + CNT_W;
	localparam int HIGH_LSB    = 2 * VW + CNT_W;
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_WAIT   = 3'b100
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        start_q;
	logic signed [VW-1:0]    low_q;
	logic signed [VW-1:0]    high_q;
	logic                    launch_q;
	logic                    hold_found_q;
	logic [IDX_W-1:0]        hold_pos_q;
	logic                    out_valid_q;
	logic                    out_found_q;
	logic [IDX_W-1:0]        out_pos_q;

	logic                    accept;
	nivr_pkg::op_t           op;
	logic signed [VW-1:0]    in_value;
	logic                    append_en;
	logic                    out_free;
	nivr_pkg::link_t         link_last;
	logic [IDX_W-1:0]        pos_last;

	assign op        = s_tuser;
	assign in_value  = s_tdata[VW-1:0];
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign append_en = accept && (op == nivr_pkg::OP_APPEND) && (count_q < FULL_COUNT);
	assign out_free  = !out_valid_q || m_tready;

	// Command decode and the table fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			launch_q <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op)
							nivr_pkg::OP_APPEND: begin
								if (count_q < FULL_COUNT) begin
									count_q <= count_q + 1'b1;
								end
							end
							nivr_pkg::OP_QUERY: begin
								launch_q <= 1'b1;
								state_q  <= S_SEARCH;
							end
							nivr_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (link_last.active) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Query operands are held steady while the token walks the row.
	always_ff @(posedge clk) begin
		if (accept && (op == nivr_pkg::OP_QUERY)) begin
			start_q <= s_tdata[START_LSB +: CNT_W];
			low_q   <= s_tdata[LOW_LSB +: VW];
			high_q  <= s_tdata[HIGH_LSB +: VW];
		end
	end

	nivr_chain #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_chain (
		.clk          (clk),
		.arst_n       (arst_n),
		.append_en    (append_en),
		.append_value (in_value),
		.count        (count_q),
		.start        (start_q),
		.range_low    (low_q),
		.range_high   (high_q),
		.launch       (launch_q),
		.link_last    (link_last),
		.pos_last     (pos_last)
	);

	// Catch the token as it leaves the last cell.
	always_ff @(posedge clk) begin
		if ((state_q == S_SEARCH) && link_last.active) begin
			hold_found_q <= link_last.found;
			hold_pos_q   <= link_last.found ? pos_last : '0;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_WAIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_WAIT) && out_free) begin
			out_found_q <= hold_found_q;
			out_pos_q   <= hold_pos_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = OUT_TDATA_W'(out_pos_q);

	// The token only leaves the row while a query is being searched.
	a_token_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		link_last.active |-> (state_q == S_SEARCH))
		else $error("search token left the chain outside a search");

	// The fill count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count above table depth");

	// The table does not change under a running search.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |=> $stable(count_q))
		else $error("entry count changed during a search");

	// An accepted query starts the token on the next cycle.
	a_query_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == nivr_pkg::OP_QUERY)) |=> (launch_q && (state_q == S_SEARCH)))
		else $error("accepted query did not launch a search");

	// A miss always reports position zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_pos_q == '0))
		else $error("not-found answer with nonzero position");

endmodule
